// ----- sv/arpc_pkg.sv -----
`timescale 1ns / 1ps

package arpc_pkg;

  localparam int unsigned IpW  = 32;
  localparam int unsigned MacW = 48;

  // Item codes carried in the mode field.
  localparam logic MODE_SAVE = 1'b0;
  localparam logic MODE_FIND = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } arpc_state_e;

  // Strobes from the sequencer to the entry store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } arpc_mem_cmd_t;

endpackage

// ----- sv/arpc_if.sv -----
`timescale 1ns / 1ps

interface arpc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [arpc_pkg::IpW-1:0]      ip_addr;
  logic [arpc_pkg::MacW-1:0]     new_mac;

  modport source (output valid, output mode, output ip_addr, output new_mac, input ready);
  modport sink   (input valid, input mode, input ip_addr, input new_mac, output ready);
endinterface

interface arpc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [arpc_pkg::MacW-1:0]     found_mac;

  modport source (output valid, output hit, output found_mac, input ready);
  modport sink   (input valid, input hit, input found_mac, output ready);
endinterface

// ----- sv/arpc_store.sv -----
`timescale 1ns / 1ps

module arpc_store #(
  parameter int unsigned ENTRIES = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  arpc_pkg::arpc_mem_cmd_t     cmd_i,
  input  logic [$clog2(ENTRIES)-1:0]  wr_addr_i,
  input  logic [arpc_pkg::IpW-1:0]    wr_ip_i,
  input  logic [arpc_pkg::MacW-1:0]   wr_mac_i,
  input  logic [$clog2(ENTRIES)-1:0]  rd_addr_i,
  output logic [arpc_pkg::IpW-1:0]    rd_ip_o,
  output logic [arpc_pkg::MacW-1:0]   rd_mac_o
);

  logic [arpc_pkg::IpW-1:0]  ip_mem  [ENTRIES];
  logic [arpc_pkg::MacW-1:0] mac_mem [ENTRIES];
  logic [ENTRIES-1:0]        valid_q;
  logic [arpc_pkg::IpW-1:0]  rd_ip_q;
  logic [arpc_pkg::MacW-1:0] rd_mac_q;
  logic                      rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      ip_mem[wr_addr_i]  <= wr_ip_i;
      mac_mem[wr_addr_i] <= wr_mac_i;
    end
    if (cmd_i.rd_en) begin
      rd_ip_q  <= ip_mem[rd_addr_i];
      rd_mac_q <= mac_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  // An entry never written since reset reads as zero.
  assign rd_ip_o  = rd_vld_q ? rd_ip_q  : '0;
  assign rd_mac_o = rd_vld_q ? rd_mac_q : '0;

endmodule

// ----- sv/arpc_ctrl.sv -----
`timescale 1ns / 1ps

module arpc_ctrl #(
  parameter int unsigned ENTRIES = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  arpc_in_if.sink                     in_i,
  arpc_out_if.source                  out_o,
  output arpc_pkg::arpc_mem_cmd_t     cmd_o,
  output logic [$clog2(ENTRIES)-1:0]  wr_addr_o,
  output logic [arpc_pkg::IpW-1:0]    wr_ip_o,
  output logic [arpc_pkg::MacW-1:0]   wr_mac_o,
  output logic [$clog2(ENTRIES)-1:0]  rd_addr_o,
  input  logic [arpc_pkg::IpW-1:0]    rd_ip_i,
  input  logic [arpc_pkg::MacW-1:0]   rd_mac_i
);

  localparam int unsigned PtrW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(ENTRIES - 1);
  localparam logic [CntW-1:0] AllRead  = CntW'(ENTRIES);

  arpc_pkg::arpc_state_e state_q, state_d;

  logic [PtrW-1:0]           wptr_q, wptr_d;
  logic [PtrW-1:0]           slot_q, slot_d;
  logic [CntW-1:0]           issued_q, issued_d;
  logic                      pend_q, pend_d;
  logic [arpc_pkg::IpW-1:0]  key_q, key_d;
  logic                      res_hit_q, res_hit_d;
  logic [arpc_pkg::MacW-1:0] res_mac_q, res_mac_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_hit_q, out_hit_d;
  logic [arpc_pkg::MacW-1:0] out_mac_q, out_mac_d;

  logic accept;
  logic out_free;
  logic match;
  logic issue;

  function automatic logic [PtrW-1:0] prev_slot(input logic [PtrW-1:0] s);
    prev_slot = (s == '0) ? LastSlot : s - PtrW'(1);
  endfunction

  assign in_i.ready = (state_q == arpc_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign match      = pend_q && (rd_ip_i == key_q);
  assign issue      = (state_q == arpc_pkg::ST_SCAN) && (issued_q != AllRead);

  assign wr_addr_o = wptr_q;
  assign wr_ip_o   = in_i.ip_addr;
  assign wr_mac_o  = in_i.new_mac;
  assign rd_addr_o = slot_q;

  always_comb begin
    state_d     = state_q;
    wptr_d      = wptr_q;
    slot_d      = slot_q;
    issued_d    = issued_q;
    pend_d      = 1'b0;
    key_d       = key_q;
    res_hit_d   = res_hit_q;
    res_mac_d   = res_mac_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_hit_d   = out_hit_q;
    out_mac_d   = out_mac_q;
    cmd_o       = '0;

    case (state_q)
      arpc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_i.mode == arpc_pkg::MODE_SAVE) begin
            cmd_o.wr_en = 1'b1;
            wptr_d      = (wptr_q == LastSlot) ? '0 : wptr_q + PtrW'(1);
          end else begin
            // Scan starts at the newest entry, just behind the write pointer.
            key_d    = in_i.ip_addr;
            slot_d   = prev_slot(wptr_q);
            issued_d = '0;
            state_d  = arpc_pkg::ST_SCAN;
          end
        end
      end
      arpc_pkg::ST_SCAN: begin
        // Reads go out one per cycle; each is compared the cycle after it issues.
        if (issue) begin
          cmd_o.rd_en = 1'b1;
          slot_d      = prev_slot(slot_q);
          issued_d    = issued_q + CntW'(1);
          pend_d      = 1'b1;
        end
        if (match || (pend_q && !issue)) begin
          pend_d = 1'b0;
          if (out_free) begin
            out_valid_d = 1'b1;
            out_hit_d   = match;
            out_mac_d   = match ? rd_mac_i : '0;
            state_d     = arpc_pkg::ST_IDLE;
          end else begin
            res_hit_d = match;
            res_mac_d = match ? rd_mac_i : '0;
            state_d   = arpc_pkg::ST_HOLD;
          end
        end
      end
      arpc_pkg::ST_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_hit_d   = res_hit_q;
          out_mac_d   = res_mac_q;
          state_d     = arpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = arpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arpc_pkg::ST_IDLE;
      wptr_q      <= '0;
      slot_q      <= '0;
      issued_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      slot_q      <= slot_d;
      issued_q    <= issued_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    res_hit_q <= res_hit_d;
    res_mac_q <= res_mac_d;
    out_hit_q <= out_hit_d;
    out_mac_q <= out_mac_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.hit       = out_hit_q;
  assign out_o.found_mac = out_mac_q;

endmodule

// ----- sv/arp_cache_ring.sv -----
`timescale 1ns / 1ps
// A save word is written as it is accepted; saves can arrive back to back.
// A find word scans one entry per cycle from the newest, one read port of the entry
// memory; its result goes to the output register, or waits in ST_HOLD if that is full.
// A new word is taken once the result is in the output register, even while it waits downstream.
// Reset is asynchronous; per-entry valid bits make all entries read as zero at once.
module arp_cache_ring #(
  parameter int unsigned ENTRIES = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  arpc_in_if.sink    in_i,
  arpc_out_if.source out_o
);

  localparam int unsigned PtrW = $clog2(ENTRIES);

  arpc_pkg::arpc_mem_cmd_t   cmd;
  logic [PtrW-1:0]           wr_addr;
  logic [arpc_pkg::IpW-1:0]  wr_ip;
  logic [arpc_pkg::MacW-1:0] wr_mac;
  logic [PtrW-1:0]           rd_addr;
  logic [arpc_pkg::IpW-1:0]  rd_ip;
  logic [arpc_pkg::MacW-1:0] rd_mac;

  arpc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .cmd_o     (cmd),
    .wr_addr_o (wr_addr),
    .wr_ip_o   (wr_ip),
    .wr_mac_o  (wr_mac),
    .rd_addr_o (rd_addr),
    .rd_ip_i   (rd_ip),
    .rd_mac_i  (rd_mac)
  );

  arpc_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .wr_addr_i (wr_addr),
    .wr_ip_i   (wr_ip),
    .wr_mac_i  (wr_mac),
    .rd_addr_i (rd_addr),
    .rd_ip_o   (rd_ip),
    .rd_mac_o  (rd_mac)
  );

  // Writes only happen for an accepted save word.
  a_write_from_save: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_en |-> (in_i.valid && in_i.ready && (in_i.mode == arpc_pkg::MODE_SAVE)))
    else $error("entry write without an accepted save word");

  // A scan never reads while a save writes.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.wr_en && cmd.rd_en))
    else $error("entry read and write in the same cycle");

  // Addresses stay inside the ring.
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd.rd_en || (32'(rd_addr) < ENTRIES)) && (!cmd.wr_en || (32'(wr_addr) < ENTRIES)))
    else $error("entry address beyond the ring");

  // A miss carries a zero MAC.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.hit) |-> (out_o.found_mac == '0))
    else $error("miss result with nonzero MAC");

endmodule
